FILE: rtl/core/tpag_pkg.sv
`timescale 1ns / 1ps
package tpag_pkg;

  localparam int SIZE_W      = 9;
  localparam int DIMS_W      = 3;
  localparam int ORDER_W     = 8;
  localparam int AXIS_W      = 2;
  localparam int NUM_SIZES   = 4;
  localparam int OFFS_W      = 32;
  localparam int CFG_DATA_W  = 9;
  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DIM_SIZE_0 = 3'd0,
    REG_DIM_SIZE_1 = 3'd1,
    REG_DIM_SIZE_2 = 3'd2,
    REG_DIM_SIZE_3 = 3'd3,
    REG_DIMS_USED  = 3'd4,
    REG_AXIS_ORDER = 3'd5
  } reg_index_t;

  // odometer carry travelling from the innermost cell outward
  typedef struct packed {
    logic              carry;
    logic [OFFS_W-1:0] delta;
  } chain_t;

  typedef struct packed {
    logic restart;
    logic step;
    logic clear;
  } cmd_t;

endpackage

FILE: rtl/core/tpag_in_if.sv
`timescale 1ns / 1ps
interface tpag_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

FILE: rtl/core/tpag_out_if.sv
`timescale 1ns / 1ps
interface tpag_out_if;
  import tpag_pkg::*;

  logic              valid;
  logic              ready;
  logic [OFFS_W-1:0] dest_offset;
  logic [OFFS_W-1:0] source_offset;
  logic              last;
  logic              order_error;

  modport source (output valid, output dest_offset, output source_offset, output last,
                  output order_error, input ready);
  modport sink (input valid, input dest_offset, input source_offset, input last,
                input order_error, output ready);
endinterface

FILE: rtl/core/tpag_cell.sv
`timescale 1ns / 1ps
module tpag_cell #(
  parameter int DIM_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [DIM_BITS-1:0]         nm1,
  input  logic [tpag_pkg::OFFS_W-1:0] stride,
  input  logic [tpag_pkg::OFFS_W-1:0] sum_in,
  output logic [tpag_pkg::OFFS_W-1:0] sum_out,
  input  tpag_pkg::cmd_t              cmd,
  input  tpag_pkg::chain_t            chain_in,
  output tpag_pkg::chain_t            chain_out
);
  import tpag_pkg::*;

  logic [DIM_BITS-1:0] idx;
  logic [DIM_BITS-1:0] idx_view;
  logic [DIM_BITS-1:0] idx_next;
  logic [OFFS_W-1:0]   wrap;
  logic [OFFS_W-1:0]   tail;
  logic [OFFS_W-1:0]   inc_delta;
  logic                at_max;

  // setup terms: wrap is what this digit takes back when it rolls over,
  // tail what all inner digits take back together
  always_ff @(posedge clk) begin
    wrap      <= OFFS_W'(nm1 * stride);
    tail      <= sum_in;
    inc_delta <= stride - tail;
  end

  assign sum_out = wrap + tail;

  always_comb begin
    idx_view = cmd.restart ? '0 : idx;
    at_max   = !(idx_view < nm1);
    chain_out.carry = chain_in.carry & at_max;
    chain_out.delta = (chain_in.carry && !at_max) ? inc_delta : chain_in.delta;
    if (!chain_in.carry) begin
      idx_next = idx_view;
    end else if (at_max) begin
      idx_next = '0;
    end else begin
      idx_next = idx_view + DIM_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      idx <= '0;
    end else if (cmd.step) begin
      idx <= idx_next;
    end
  end

endmodule

FILE: rtl/core/tensor_permute_address_generator_unit.sv
`timescale 1ns / 1ps
// Permute address generator. Each beat on in_ch (restart bit) yields one beat on
// out_ch: the next element's row-major offset in the permuted tensor, the offset
// of that element in the source, a last flag, and order_error for an axis order
// that is not a permutation of the dimensions in use (offsets and last then 0).
// Shape is set through the write port (cfg_write, cfg_index, cfg_data); any write
// to a known register restarts the walk at element zero.
// The output beat is registered; one beat is taken every cycle when setup is
// done and out_ch is not stalled. The output register frees up in the same
// cycle it is taken, so a stall on out_ch only holds in_ch.ready low while the
// result waits. The odometer is a row of MAX_DIMS cells, one per output
// dimension; the carry ripples from the innermost cell outward and picks the
// source offset step. After reset and after each register write the block holds
// in_ch.ready low while the stride products and rollover sums settle down
// the cell row. Reset loads sizes 1, four dimensions and the identity order.
module tensor_permute_address_generator_unit #(
  parameter int MAX_DIMS = 4,
  parameter int DIM_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [tpag_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tpag_pkg::CFG_DATA_W-1:0]  cfg_data,
  tpag_in_if.sink                          in_ch,
  tpag_out_if.source                       out_ch
);
  import tpag_pkg::*;

  localparam int          SETUP_CYCLES = 2 * MAX_DIMS + 2;
  localparam int          CNT_W        = $clog2(SETUP_CYCLES + 1);
  localparam int unsigned SIZE_TOP     = 1 << DIM_BITS;

  logic [SIZE_W-1:0]   dim_size [NUM_SIZES];
  logic [DIMS_W-1:0]   dims_used;
  logic [ORDER_W-1:0]  axis_order;
  logic [CNT_W-1:0]    setup_cnt;

  logic [DIMS_W-1:0]   d_eff;
  logic [AXIS_W-1:0]   ax [MAX_DIMS];
  logic [SIZE_W-1:0]   szp [MAX_DIMS];
  logic [OFFS_W-1:0]   sprod [MAX_DIMS];
  logic [DIM_BITS-1:0] nm1 [MAX_DIMS];
  logic [OFFS_W-1:0]   stride_sel [MAX_DIMS];
  logic [OFFS_W-1:0]   sums [MAX_DIMS+1];
  chain_t              chain [MAX_DIMS+1];
  cmd_t                cmd;
  logic                err;
  logic [3:0]          seen;
  logic                cfg_hit;
  logic                accept;
  logic                last;
  logic [OFFS_W-1:0]   src_off;
  logic [OFFS_W-1:0]   dst_off;
  logic [OFFS_W-1:0]   src_view;
  logic [OFFS_W-1:0]   dst_view;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s == '0) begin
      r = SIZE_W'(1);
    end else if (32'(s) > SIZE_TOP) begin
      r = SIZE_W'(SIZE_TOP);
    end
    return r;
  endfunction

  // configuration registers
  always_comb begin
    case (reg_index_t'(cfg_index))
      REG_DIM_SIZE_0, REG_DIM_SIZE_1, REG_DIM_SIZE_2, REG_DIM_SIZE_3,
      REG_DIMS_USED, REG_AXIS_ORDER: cfg_hit = cfg_write;
      default:                       cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SIZES; i++) dim_size[i] <= SIZE_W'(1);
      dims_used  <= DIMS_W'(4);
      axis_order <= ORDER_W'(228);
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_DIM_SIZE_0: dim_size[0] <= cfg_data;
        REG_DIM_SIZE_1: dim_size[1] <= cfg_data;
        REG_DIM_SIZE_2: dim_size[2] <= cfg_data;
        REG_DIM_SIZE_3: dim_size[3] <= cfg_data;
        REG_DIMS_USED:  dims_used   <= cfg_data[DIMS_W-1:0];
        REG_AXIS_ORDER: axis_order  <= cfg_data[ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      setup_cnt <= CNT_W'(SETUP_CYCLES);
    end else if (setup_cnt != '0) begin
      setup_cnt <= setup_cnt - CNT_W'(1);
    end
  end

  // decoded shape
  always_comb begin
    if (dims_used == '0) begin
      d_eff = DIMS_W'(1);
    end else if (32'(dims_used) > MAX_DIMS) begin
      d_eff = DIMS_W'(MAX_DIMS);
    end else begin
      d_eff = dims_used;
    end
    err  = 1'b0;
    seen = '0;
    for (int j = 0; j < MAX_DIMS; j++) begin
      ax[j] = axis_order[AXIS_W*j +: AXIS_W];
      if (32'(j) < 32'(d_eff)) begin
        if ({1'b0, ax[j]} >= d_eff || seen[ax[j]]) begin
          err = 1'b1;
        end else begin
          seen[ax[j]] = 1'b1;
        end
        nm1[j] = DIM_BITS'(eff_size(dim_size[ax[j]]) - SIZE_W'(1));
      end else begin
        nm1[j] = '0;
      end
      szp[j] = (32'(j) < 32'(d_eff)) ? eff_size(dim_size[j]) : SIZE_W'(1);
      stride_sel[j] = '0;
      for (int i = 0; i < MAX_DIMS; i++) begin
        if (32'(ax[j]) == i) stride_sel[j] = sprod[i];
      end
    end
  end

  // source strides: one product per axis, settling inward to outward
  for (genvar i = 0; i < MAX_DIMS; i++) begin : g_stride
    if (i == MAX_DIMS - 1) begin : g_inner
      always_ff @(posedge clk) sprod[i] <= OFFS_W'(1);
    end else begin : g_outer
      always_ff @(posedge clk) sprod[i] <= OFFS_W'(szp[i+1] * sprod[i+1]);
    end
  end

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (setup_cnt == '0) && (!out_ch.valid || out_ch.ready);

  assign cmd.restart = in_ch.restart;
  assign cmd.step    = accept && !err;
  assign cmd.clear   = cfg_hit || (accept && err && in_ch.restart) ||
                       (accept && !err && last);

  assign chain[MAX_DIMS].carry = 1'b1;
  assign chain[MAX_DIMS].delta = '0;
  assign sums[MAX_DIMS]        = '0;

  for (genvar j = 0; j < MAX_DIMS; j++) begin : g_cell
    tpag_cell #(
      .DIM_BITS(DIM_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .nm1      (nm1[j]),
      .stride   (stride_sel[j]),
      .sum_in   (sums[j+1]),
      .sum_out  (sums[j]),
      .cmd      (cmd),
      .chain_in (chain[j+1]),
      .chain_out(chain[j])
    );
  end

  assign last     = chain[0].carry;
  assign src_view = in_ch.restart ? '0 : src_off;
  assign dst_view = in_ch.restart ? '0 : dst_off;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      src_off <= '0;
      dst_off <= '0;
    end else if (cmd.step) begin
      src_off <= src_view + chain[0].delta;
      dst_off <= dst_view + OFFS_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (accept) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.dest_offset   <= err ? '0 : dst_view;
      out_ch.source_offset <= err ? '0 : src_view;
      out_ch.last          <= !err && last;
      out_ch.order_error   <= err;
    end
  end

endmodule
